// ===== design/vno2d_pkg.sv =====
// Shared constants, types and the cosine curve table of the 2D value noise block.
`default_nettype none

package vno2d_pkg;

  localparam int TABLE_DEPTH   = 4096;
  localparam int MAX_OCTAVES   = 8;
  localparam int CURVE_ENTRIES = 256;

  localparam int TAB_AW    = $clog2(TABLE_DEPTH);
  localparam int OCT_W     = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int OCT_SHIFT = MAX_OCTAVES - 1;
  localparam int CX_W      = 16 + OCT_SHIFT;
  localparam int Q_W       = 32 + OCT_SHIFT;
  localparam int ADDR_W    = CX_W + 13 + 2;
  localparam int SUM_W     = 32 + $clog2(MAX_OCTAVES) + 1;
  localparam int DIV_W     = SUM_W + 17;
  localparam int DVS_W     = 17;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int MUL_AW    = ((SUM_W > CX_W) ? SUM_W : CX_W) + 1;
  localparam int MUL_BW    = 18;
  localparam int PROD_W    = MUL_AW + MUL_BW;
  localparam int CURVE_AW  = $clog2(CURVE_ENTRIES);
  localparam int APB_AW    = 4;

  localparam logic [63:0] PI_Q30  = 64'd3373259422;
  localparam longint      ONE_Q30 = 64'sd1073741824;

  typedef logic [16:0] curve_rom_t [CURVE_ENTRIES];

  // (1-cos(pi*e/N))/2 in Q16 by a Q30 Taylor series
  function automatic logic [16:0] curve_half(int unsigned e);
    logic [63:0] theta;
    logic [63:0] t2;
    logic [63:0] term;
    longint      c;
    theta = (PI_Q30 * 64'(e)) / CURVE_ENTRIES;
    t2    = (theta * theta) >> 30;
    term  = 64'(ONE_Q30);
    c     = ONE_Q30;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) c = c - longint'(term);
      else c = c + longint'(term);
    end
    if (c < 0) c = 0;
    if (c > ONE_Q30) c = ONE_Q30;
    return 17'((64'(ONE_Q30 - c) + 64'd16384) >> 15);
  endfunction

  function automatic curve_rom_t build_curve();
    curve_rom_t r;
    for (int unsigned e = 0; e < CURVE_ENTRIES; e++) begin
      if (2 * e <= CURVE_ENTRIES) r[e] = curve_half(e);
      else r[e] = 17'h10000 - curve_half(CURVE_ENTRIES - e);
    end
    return r;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

  typedef struct packed {
    logic [3:0]  octave_count;
    logic [8:0]  lattice_step;
    logic [12:0] row_stride;
    logic [15:0] persistence;
  } vno2d_cfg_t;

  typedef struct packed {
    logic        func;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [11:0] table_addr;
    logic [15:0] table_value;
  } vno2d_item_t;

  typedef struct packed {
    logic [15:0] noise_value;
    logic        index_error;
  } vno2d_result_t;

  localparam logic FUNC_WRITE = 1'b0;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE, OP_LOAD, OP_DIVY, OP_INIT, OP_CELL, OP_MADDR, OP_BASE,
    OP_RD, OP_MBL1, OP_MBL2, OP_V2, OP_MBL3, OP_VV, OP_MPV, OP_MPP, OP_PUPD,
    OP_MFIN, OP_DIVF, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] corner;
  } vno2d_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_oct;
    logic err;
  } vno2d_stat_t;

endpackage

`default_nettype wire

// ===== design/vno2d_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vno2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/vno2d_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module vno2d_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [vno2d_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [vno2d_pkg::DVS_W-1:0]   divisor_i,
  input  wire logic [vno2d_pkg::CNT_W-1:0]   iters_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic      [vno2d_pkg::DIV_W-1:0]   quo_o
);
  import vno2d_pkg::*;

  logic             run_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] dvd_q, quo_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= iters_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o = run_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q) else $error("divider done while still running");

endmodule

`default_nettype wire

// ===== design/vno2d_dp.sv =====
// Datapath: lattice table, divider, shared multiplier, blending and accumulation.
`default_nettype none

module vno2d_dp (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire vno2d_pkg::vno2d_cmd_t    cmd_i,
  input  wire vno2d_pkg::vno2d_item_t   item_i,
  input  wire vno2d_pkg::vno2d_cfg_t    cfg_i,
  output vno2d_pkg::vno2d_stat_t        stat_o,
  output vno2d_pkg::vno2d_result_t      result_o,
  output logic                          result_valid_o
);
  import vno2d_pkg::*;

  function automatic logic signed [16:0] diff16(logic [15:0] b, logic [15:0] a);
    return $signed({1'b0, b}) - $signed({1'b0, a});
  endfunction

  // a*65536 + (b-a)*k, rounded back to Q16
  function automatic logic [15:0] blend_out(logic signed [PROD_W-1:0] p, logic [15:0] a);
    logic signed [PROD_W:0] t;
    t = $signed({1'b0, {(PROD_W-32){1'b0}}, a, 16'b0}) + (PROD_W+1)'(p)
        + (PROD_W+1)'(32768);
    return t[31:16];
  endfunction

  logic [15:0]              y_q;
  logic [Q_W-1:0]           qx_q, qy_q;
  logic [OCT_W-1:0]         oct_q, n_last;
  logic [CX_W-1:0]          cx_q, cy_q;
  logic [16:0]              kx_q, ky_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ADDR_W-1:0]        base_q, caddr;
  logic [15:0]              corner_q [4];
  logic                     rd_pend_q;
  logic [1:0]               rd_idx_q;
  logic [15:0]              v1_q, v2_q, v_q;
  logic [SUM_W-1:0]         sum_q;
  logic [16:0]              p_q, omp, den;
  logic                     err_q;
  vno2d_result_t            res_q;
  logic                     res_valid_q;

  logic [Q_W+OCT_SHIFT-1:0] shx, shy;
  logic [15:0]              fx, fy;
  logic [8:0]               step;
  logic                     oob;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic [33:0]              p_round;
  logic [DIV_W:0]           q_round;

  logic                     div_start, div_busy, div_done;
  logic [DIV_W-1:0]         dividend, div_quo;
  logic [DVS_W-1:0]         divisor;
  logic [CNT_W-1:0]         iters;
  logic [15:0]              ram_rdata;

  assign step = (cfg_i.lattice_step == '0) ? 9'd1 : cfg_i.lattice_step;
  assign omp  = 17'h10000 - {1'b0, cfg_i.persistence};
  assign den  = (p_q == 17'h10000) ? 17'd1 : 17'h10000 - p_q;

  always_comb begin
    if (cfg_i.octave_count == '0) n_last = '0;
    else if (32'(cfg_i.octave_count) > MAX_OCTAVES) n_last = OCT_W'(MAX_OCTAVES - 1);
    else n_last = OCT_W'(cfg_i.octave_count - 4'd1);
  end

  // scaled coordinate: cell in the top bits, Q16 fraction below
  assign shx = (Q_W+OCT_SHIFT)'(qx_q) << oct_q;
  assign shy = (Q_W+OCT_SHIFT)'(qy_q) << oct_q;
  assign fx  = shx[OCT_SHIFT +: 16];
  assign fy  = shy[OCT_SHIFT +: 16];

  assign caddr = base_q + (cmd_i.corner[0] ? ADDR_W'(cfg_i.row_stride) : '0)
                 + ADDR_W'(cmd_i.corner[1]);
  assign oob   = caddr >= ADDR_W'(TABLE_DEPTH);

  assign div_start = (cmd_i.op == OP_LOAD) || (cmd_i.op == OP_DIVY)
                     || (cmd_i.op == OP_DIVF);

  always_comb begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        dividend = {item_i.x_coord, (DIV_W-16)'(0)};
        divisor  = DVS_W'(step);
        iters    = CNT_W'(Q_W);
      end
      OP_DIVF: begin
        dividend = DIV_W'(prod_q);
        divisor  = den;
        iters    = CNT_W'(DIV_W);
      end
      default: begin
        dividend = {y_q, (DIV_W-16)'(0)};
        divisor  = DVS_W'(step);
        iters    = CNT_W'(Q_W);
      end
    endcase
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_MADDR: begin
        mul_a = MUL_AW'(cx_q);
        mul_b = MUL_BW'(cfg_i.row_stride);
      end
      OP_MBL1: begin
        mul_a = MUL_AW'(diff16(corner_q[1], corner_q[0]));
        mul_b = MUL_BW'(kx_q);
      end
      OP_MBL2: begin
        mul_a = MUL_AW'(diff16(corner_q[3], corner_q[2]));
        mul_b = MUL_BW'(kx_q);
      end
      OP_MBL3: begin
        mul_a = MUL_AW'(diff16(v2_q, v1_q));
        mul_b = MUL_BW'(ky_q);
      end
      OP_MPV: begin
        mul_a = MUL_AW'(p_q);
        mul_b = MUL_BW'(v_q);
      end
      OP_MPP: begin
        mul_a = MUL_AW'(p_q);
        mul_b = MUL_BW'(cfg_i.persistence);
      end
      OP_MFIN: begin
        mul_a = MUL_AW'(sum_q);
        mul_b = MUL_BW'(omp);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign p_round = 34'(prod_q[32:0]) + 34'd32768;
  assign q_round = {1'b0, div_quo} + (DIV_W+1)'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rd_pend_q   <= cmd_i.op == OP_RD;
      res_valid_q <= (cmd_i.op == OP_WRITE) || (cmd_i.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= mul_a * mul_b;
    rd_idx_q <= cmd_i.corner;
    if (rd_pend_q) corner_q[rd_idx_q] <= ram_rdata;
    unique case (cmd_i.op)
      OP_WRITE: res_q <= '0;
      OP_LOAD:  y_q <= item_i.y_coord;
      OP_DIVY:  qx_q <= div_quo[Q_W-1:0];
      OP_INIT: begin
        qy_q  <= div_quo[Q_W-1:0];
        oct_q <= '0;
        sum_q <= '0;
        p_q   <= 17'h10000;
        err_q <= 1'b0;
      end
      OP_CELL: begin
        cx_q <= shx[Q_W+OCT_SHIFT-1 -: CX_W];
        cy_q <= shy[Q_W+OCT_SHIFT-1 -: CX_W];
        kx_q <= CURVE_ROM[fx[15 -: CURVE_AW]];
        ky_q <= CURVE_ROM[fy[15 -: CURVE_AW]];
      end
      OP_BASE: base_q <= ADDR_W'(prod_q) + ADDR_W'(cy_q);
      OP_RD:   if (oob) err_q <= 1'b1;
      OP_MBL2: v1_q <= blend_out(prod_q, corner_q[0]);
      OP_V2:   v2_q <= blend_out(prod_q, corner_q[2]);
      OP_VV:   v_q <= blend_out(prod_q, v1_q);
      OP_MPP:  sum_q <= sum_q + SUM_W'(prod_q);
      OP_PUPD: begin
        p_q   <= p_round[32:16];
        oct_q <= oct_q + 1'b1;
      end
      OP_EMIT: begin
        res_q.index_error <= err_q;
        if (err_q) res_q.noise_value <= '0;
        else if (|q_round[DIV_W:32]) res_q.noise_value <= 16'hFFFF;
        else res_q.noise_value <= q_round[31:16];
      end
      default: ;
    endcase
  end

  vno2d_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .iters_i    (iters),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  vno2d_ram #(
    .Width (16),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    ((cmd_i.op == OP_WRITE) && (32'(item_i.table_addr) < TABLE_DEPTH)),
    .waddr_i (TAB_AW'(item_i.table_addr)),
    .wdata_i (item_i.table_value),
    .re_i    (cmd_i.op == OP_RD),
    .raddr_i (caddr[TAB_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign stat_o.div_done = div_done;
  assign stat_o.last_oct = oct_q == n_last;
  assign stat_o.err      = err_q;
  assign result_o        = res_q;
  assign result_valid_o  = res_valid_q;

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.index_error) |-> (res_q.noise_value == '0))
    else $error("index error with nonzero noise");

endmodule

`default_nettype wire

// ===== design/vno2d_ctrl.sv =====
// Sequencer: steps the datapath through divisions, octaves and the final scale.
`default_nettype none

module vno2d_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic                   func_i,
  input  wire vno2d_pkg::vno2d_stat_t stat_i,
  output vno2d_pkg::vno2d_cmd_t       cmd_o,
  output logic                        busy_o
);
  import vno2d_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DIVX, S_DIVY, S_CELL, S_MADDR, S_BASE, S_RD0, S_RD1, S_RD2, S_RD3,
    S_MBL1, S_MBL2, S_V2, S_MBL3, S_VV, S_MPV, S_MPP, S_PUPD, S_MFIN, S_DIVF,
    S_WAITF, S_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op     = OP_NONE;
    cmd_o.corner = 2'd0;
    unique case (state_q)
      S_IDLE: if (start_i) begin
        if (func_i == FUNC_WRITE) cmd_o.op = OP_WRITE;
        else begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DIVX;
        end
      end
      S_DIVX: if (stat_i.div_done) begin
        cmd_o.op = OP_DIVY;
        state_d  = S_DIVY;
      end
      S_DIVY: if (stat_i.div_done) begin
        cmd_o.op = OP_INIT;
        state_d  = S_CELL;
      end
      S_CELL: begin
        cmd_o.op = OP_CELL;
        state_d  = S_MADDR;
      end
      S_MADDR: begin
        cmd_o.op = OP_MADDR;
        state_d  = S_BASE;
      end
      S_BASE: begin
        cmd_o.op = OP_BASE;
        state_d  = S_RD0;
      end
      S_RD0: begin
        cmd_o.op = OP_RD;
        state_d  = S_RD1;
      end
      S_RD1: begin
        cmd_o.op     = OP_RD;
        cmd_o.corner = 2'd1;
        state_d      = S_RD2;
      end
      S_RD2: begin
        cmd_o.op     = OP_RD;
        cmd_o.corner = 2'd2;
        state_d      = S_RD3;
      end
      S_RD3: begin
        cmd_o.op     = OP_RD;
        cmd_o.corner = 2'd3;
        state_d      = S_MBL1;
      end
      S_MBL1: begin
        cmd_o.op = OP_MBL1;
        state_d  = S_MBL2;
      end
      S_MBL2: begin
        cmd_o.op = OP_MBL2;
        state_d  = S_V2;
      end
      S_V2: begin
        cmd_o.op = OP_V2;
        state_d  = S_MBL3;
      end
      S_MBL3: begin
        cmd_o.op = OP_MBL3;
        state_d  = S_VV;
      end
      S_VV: begin
        cmd_o.op = OP_VV;
        state_d  = S_MPV;
      end
      S_MPV: begin
        cmd_o.op = OP_MPV;
        state_d  = S_MPP;
      end
      S_MPP: begin
        cmd_o.op = OP_MPP;
        state_d  = S_PUPD;
      end
      S_PUPD: begin
        cmd_o.op = OP_PUPD;
        // skip the final scale once a corner has missed the table
        if (!stat_i.last_oct) state_d = S_CELL;
        else if (stat_i.err) state_d = S_EMIT;
        else state_d = S_MFIN;
      end
      S_MFIN: begin
        cmd_o.op = OP_MFIN;
        state_d  = S_DIVF;
      end
      S_DIVF: begin
        cmd_o.op = OP_DIVF;
        state_d  = S_WAITF;
      end
      S_WAITF: if (stat_i.div_done) state_d = S_EMIT;
      S_EMIT: begin
        cmd_o.op = OP_EMIT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign busy_o = state_q != S_IDLE;

  a_final_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAITF && stat_i.div_done) |=> state_q == S_EMIT)
    else $error("final quotient not emitted");

endmodule

`default_nettype wire

// ===== design/value_noise_2d_octaves.sv =====
// Top level of the multi-octave 2D value noise block with its register port.
`default_nettype none

// A word with func 0 writes one Q0.16 lattice value and its result (zero) strobes
// on result_valid_o the next cycle; busy stays low, so writes go one per cycle.
// An evaluate word keeps busy high through two bit-serial divisions of x and y by
// the lattice step (39 quotient bits each), one pass per octave through the shared
// multiplier and the single table read port, then the normalization multiply and
// 53-bit division, and the registering of the result. When a corner misses the
// table the normalization is skipped. The result strobes in the first cycle after
// busy falls. Each result is shown for exactly one cycle and cannot be held off.
// Configuration registers sit at byte addresses 0, 4, 8 and 12.
module value_noise_2d_octaves (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  input  wire vno2d_pkg::vno2d_item_t             item_i,
  output logic                                    busy,
  output logic                                    result_valid_o,
  output vno2d_pkg::vno2d_result_t                result_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [vno2d_pkg::APB_AW-1:0]       paddr,
  input  wire logic [31:0]                        pwdata,
  output logic      [31:0]                        prdata,
  output logic                                    pready
);
  import vno2d_pkg::*;

  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_STEP    = 2'd1;
  localparam logic [1:0] REG_STRIDE  = 2'd2;
  localparam logic [1:0] REG_PERSIST = 2'd3;

  vno2d_cfg_t  cfg_q;
  vno2d_cmd_t  cmd;
  vno2d_stat_t stat;
  logic        cfg_we;
  logic        accept;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.octave_count <= 4'd4;
      cfg_q.lattice_step <= 9'd16;
      cfg_q.row_stride   <= 13'd64;
      cfg_q.persistence  <= 16'd32768;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_OCTAVES: cfg_q.octave_count <= pwdata[3:0];
        REG_STEP:    cfg_q.lattice_step <= pwdata[8:0];
        REG_STRIDE:  cfg_q.row_stride   <= pwdata[12:0];
        REG_PERSIST: cfg_q.persistence  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_OCTAVES: prdata = 32'(cfg_q.octave_count);
      REG_STEP:    prdata = 32'(cfg_q.lattice_step);
      REG_STRIDE:  prdata = 32'(cfg_q.row_stride);
      REG_PERSIST: prdata = 32'(cfg_q.persistence);
      default:     prdata = '0;
    endcase
  end

  vno2d_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .func_i  (item_i.func),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  vno2d_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (item_i),
    .cfg_i          (cfg_q),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  a_result_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(accept) || $past(busy)))
    else $error("result word without a pending item");

endmodule

`default_nettype wire

// ===== bench/value_noise_2d_octaves_tb.sv =====
// Self-checking testbench for the multi-octave 2D value noise block.
`default_nettype none

module value_noise_2d_octaves_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vno2d_pkg::*;

  localparam logic [3:0] REG_OCTAVES = 4'd0;
  localparam logic [3:0] REG_STEP    = 4'd4;
  localparam logic [3:0] REG_STRIDE  = 4'd8;
  localparam logic [3:0] REG_PERSIST = 4'd12;
  localparam logic       FUNC_EVAL   = 1'b1;
  localparam longint     CYCLE_LIMIT = 64'd2_000_000;

  // Predicts noise results and holds the ones still due from the block.
  class noise_scoreboard;
    logic [15:0]   lattice [TABLE_DEPTH];
    logic [16:0]   curve [CURVE_ENTRIES];
    logic [3:0]    octaves;
    logic [8:0]    step;
    logic [12:0]   stride;
    logic [15:0]   persist;
    vno2d_result_t due_q[$];
    int            errors;

    function new();
      longint unsigned th, t2, term;
      longint          c;
      logic [16:0]     h [CURVE_ENTRIES + 1];
      for (int e = 0; e <= CURVE_ENTRIES; e++) begin
        th = (64'd3373259422 * longint'(e)) / CURVE_ENTRIES;
        t2 = (th * th) >> 30;
        term = 64'd1073741824;
        c = 64'sd1073741824;
        for (int n = 1; n <= 10; n++) begin
          term = ((term * t2) >> 30) / longint'((2 * n - 1) * (2 * n));
          if (n % 2 == 1) c = c - longint'(term);
          else c = c + longint'(term);
        end
        if (c < 0) c = 0;
        if (c > 64'sd1073741824) c = 64'sd1073741824;
        h[e] = 17'((longint'(64'sd1073741824 - c) + 16384) >> 15);
      end
      for (int e = 0; e < CURVE_ENTRIES; e++)
        curve[e] = (2 * e <= CURVE_ENTRIES) ? h[e] : 17'h10000 - h[CURVE_ENTRIES - e];
      octaves = 4'd4; step = 9'd16; stride = 13'd64; persist = 16'h8000;
      errors = 0;
    endfunction

    function longint unsigned weight(longint unsigned frac);
      longint unsigned idx;
      idx = (frac * CURVE_ENTRIES) >> 16;
      if (idx >= CURVE_ENTRIES) idx = CURVE_ENTRIES - 1;
      return 64'(curve[idx]);
    endfunction

    function longint unsigned mix(longint unsigned a, longint unsigned b,
                                  longint unsigned k);
      return (a * (65536 - k) + b * k + 32768) >> 16;
    endfunction

    function longint unsigned corner(longint unsigned addr, ref bit err);
      if (addr >= TABLE_DEPTH) begin
        err = 1;
        return 0;
      end
      return 64'(lattice[addr]);
    endfunction

    function void note_item(vno2d_item_t it);
      vno2d_result_t   r;
      longint unsigned n, st, sx, sy, cx, cy, fx, fy, a, b, c, d, kx, ky, v;
      longint unsigned sum, p, den, q;
      bit              err;
      r = '0;
      if (it.func == FUNC_WRITE) begin
        lattice[it.table_addr] = it.table_value;
        due_q.push_back(r);
        return;
      end
      n = (octaves == 0) ? 1 : (octaves > MAX_OCTAVES) ? MAX_OCTAVES : octaves;
      st = (step == 0) ? 1 : step;
      sum = 0; p = 65536; err = 0;
      for (int i = 0; i < n; i++) begin
        sx = longint'(it.x_coord) << i;
        sy = longint'(it.y_coord) << i;
        cx = sx / st; cy = sy / st;
        fx = ((sx % st) << 16) / st;
        fy = ((sy % st) << 16) / st;
        a = corner(cx * stride + cy, err);
        b = corner((cx + 1) * stride + cy, err);
        c = corner(cx * stride + cy + 1, err);
        d = corner((cx + 1) * stride + cy + 1, err);
        kx = weight(fx); ky = weight(fy);
        v = mix(mix(a, b, kx), mix(c, d, kx), ky);
        sum += p * v;
        p = (p * persist + 32768) >> 16;
      end
      if (err) begin
        r.index_error = 1'b1;
      end else begin
        den = 65536 - p;
        if (den == 0) den = 1;
        q = (sum * (65536 - persist)) / den;
        q = (q + 32768) >> 16;
        r.noise_value = (q > 65535) ? 16'hFFFF : q[15:0];
      end
      due_q.push_back(r);
    endfunction

    function void check_result(vno2d_result_t got);
      vno2d_result_t exp_r;
      if (due_q.size() == 0) begin
        $error("unexpected result word: noise_value %0d index_error %0d",
               got.noise_value, got.index_error);
        errors++;
        return;
      end
      exp_r = due_q.pop_front();
      if (got.noise_value !== exp_r.noise_value) begin
        $error("noise_value: expected %0d, actual %0d", exp_r.noise_value,
               got.noise_value);
        errors++;
      end
      if (got.index_error !== exp_r.index_error) begin
        $error("index_error: expected %0d, actual %0d", exp_r.index_error,
               got.index_error);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  vno2d_item_t   item_i = '0;
  logic          busy;
  logic          result_valid_o;
  vno2d_result_t result_o;
  logic          psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  noise_scoreboard sb = new();
  longint          cycles = 0;
  int              idle_pct = 0;
  bit              written [TABLE_DEPTH];

  value_noise_2d_octaves i_dut (
    .clk_i, .rst_ni, .start, .item_i, .busy, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && result_valid_o) sb.check_result(result_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (addr)
      REG_OCTAVES: sb.octaves = data[3:0];
      REG_STEP:    sb.step = data[8:0];
      REG_STRIDE:  sb.stride = data[12:0];
      default:     sb.persist = data[15:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Called at a falling edge: sender gap, then hold start until busy is low at an
  // edge. Start stays high so the next word can follow with no gap.
  task automatic send_item(vno2d_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic write_entry(int addr, logic [15:0] val);
    vno2d_item_t it;
    it = '0;
    it.func = FUNC_WRITE;
    it.table_addr = 12'(addr);
    it.table_value = val;
    it.x_coord = 16'($urandom);
    it.y_coord = 16'($urandom);
    written[addr] = 1;
    send_item(it);
  endtask

  // Write every in-table corner of the point that has not been written yet.
  task automatic fill_corners(logic [15:0] x, logic [15:0] y);
    longint unsigned n, st, cx, cy, ad;
    n = (sb.octaves == 0) ? 1 : (sb.octaves > MAX_OCTAVES) ? MAX_OCTAVES : sb.octaves;
    st = (sb.step == 0) ? 1 : sb.step;
    for (int i = 0; i < n; i++) begin
      cx = (longint'(x) << i) / st;
      cy = (longint'(y) << i) / st;
      for (int k = 0; k < 4; k++) begin
        ad = (cx + k[0]) * sb.stride + cy + k[1];
        if (ad < TABLE_DEPTH && !written[ad]) write_entry(int'(ad), 16'($urandom));
      end
    end
  endtask

  task automatic eval_point(logic [15:0] x, logic [15:0] y);
    vno2d_item_t it;
    fill_corners(x, y);
    it = '0;
    it.func = FUNC_EVAL;
    it.x_coord = x;
    it.y_coord = y;
    it.table_addr = 12'($urandom);
    it.table_value = 16'($urandom);
    send_item(it);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (sb.due_q.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  task automatic configure(int oct, int stp, int strd, int pers);
    drain();
    reg_write(REG_OCTAVES, oct);
    reg_write(REG_STEP, stp);
    reg_write(REG_STRIDE, strd);
    reg_write(REG_PERSIST, pers);
  endtask

  // Mostly near-origin points so corners stay inside the table.
  task automatic random_phase(int count);
    logic [15:0] x, y;
    int          lim;
    for (int j = 0; j < count; j++) begin
      case ($urandom_range(9))
        0: write_entry($urandom_range(TABLE_DEPTH - 1), 16'($urandom));
        1: eval_point(16'($urandom), 16'($urandom));
        default: begin
          lim = (sb.step == 0) ? 1 : sb.step;
          x = 16'($urandom_range(lim));
          y = 16'($urandom_range(lim));
          eval_point(x, y);
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes at reset settings.
    idle_pct = 0;
    write_entry(0, 16'h0000);
    write_entry(1, 16'hFFFF);
    write_entry(TABLE_DEPTH - 1, 16'hFFFF);
    eval_point(0, 0);
    eval_point(15, 15);
    eval_point(1, 2);
    eval_point(16'hFFFF, 16'hFFFF);
    eval_point(16'hFFFF, 0);
    eval_point(0, 16'hFFFF);
    // Extreme settings: zero step, zero octaves, zero stride, persistence zero.
    configure(0, 0, 0, 0);
    eval_point(0, 0);
    eval_point(7, 100);
    eval_point(0, 4094);
    configure(15, 256, 4096, 65535);
    eval_point(255, 255);
    eval_point(0, 0);
    eval_point(100, 3);
    configure(8, 1, 1, 1);
    eval_point(3, 5);
    eval_point(16'hAAAA, 16'h5555);
    configure(1, 255, 8191, 16'h8000);
    eval_point(254, 254);

    idle_pct = 16;
    configure(4, 16, 64, 32768);
    random_phase(110);
    idle_pct = 59;
    configure(8, 256, 4096, 40000);
    random_phase(110);
    idle_pct = 0;
    configure(3, 37, 100, $urandom_range(65535));
    random_phase(110);

    drain();
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (sb.due_q.size() != 0) $error("%0d results never arrived", sb.due_q.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
